@@ src/dtpg_pkg.sv @@
// ----------------------------------------------------------------------------
// Display test pattern generator package
// Shared widths, register indexes, pattern modes, pattern geometry and the
// byte-swapped RGB565 color constants.
// ----------------------------------------------------------------------------
package dtpg_pkg;

    localparam int COORD_W  = 9;
    localparam int COLOUR_W = 16;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOLID_COLOUR = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_RING  = 2'd0,
        MODE_RULER = 2'd1,
        MODE_ZONES = 2'd2,
        MODE_SOLID = 2'd3
    } t_mode;

    // Ruler and zone geometry.
    localparam int RULER_SPAN    = 64;
    localparam int ZONE_TOP      = 116;
    localparam int ZONE_ROWS     = 60;
    localparam int ZONE_COUNT    = 4;
    localparam int ZONE_SHIFT    = 8;
    localparam int ZONE_SEP_ROWS = 2;

    // Ring and cross geometry, on doubled coordinates for the rings.
    localparam logic signed [23:0] OUTER_LO = 24'sd212521;  // 461 squared
    localparam logic signed [23:0] OUTER_HI = 24'sd218089;  // 467 squared
    localparam logic signed [23:0] INNER_LO = 24'sd127449;  // 357 squared
    localparam logic signed [23:0] INNER_HI = 24'sd131769;  // 363 squared
    localparam int CROSS_ARM  = 20;
    localparam int CROSS_HALF = 1;
    localparam int EDGE_LINES = 2;

    // RGB565 with the high and low bytes swapped.
    function automatic logic [COLOUR_W-1:0] pack565(input logic [7:0] r,
                                                    input logic [7:0] g,
                                                    input logic [7:0] b);
        logic [COLOUR_W-1:0] c;
        c = {r[7:3], g[7:2], b[7:3]};
        return {c[7:0], c[15:8]};
    endfunction

    localparam logic [COLOUR_W-1:0] C_BACKGROUND = pack565(8'h10, 8'h10, 8'h14);
    localparam logic [COLOUR_W-1:0] C_RED        = pack565(8'hFF, 8'h00, 8'h00);
    localparam logic [COLOUR_W-1:0] C_GREEN      = pack565(8'h00, 8'hFF, 8'h00);
    localparam logic [COLOUR_W-1:0] C_BLUE       = pack565(8'h30, 8'h60, 8'hFF);
    localparam logic [COLOUR_W-1:0] C_YELLOW     = pack565(8'hFF, 8'hE0, 8'h00);
    localparam logic [COLOUR_W-1:0] C_MAGENTA    = pack565(8'hFF, 8'h00, 8'hFF);
    localparam logic [COLOUR_W-1:0] C_CYAN       = pack565(8'h00, 8'hE0, 8'hFF);
    localparam logic [COLOUR_W-1:0] C_WHITE      = pack565(8'hFF, 8'hFF, 8'hFF);
    localparam logic [COLOUR_W-1:0] C_ORANGE     = pack565(8'hFF, 8'h80, 8'h00);

    // Eight-entry ruler palette.
    function automatic logic [COLOUR_W-1:0] palette_colour(input logic [2:0] idx);
        logic [COLOUR_W-1:0] c;
        case (idx)
            3'd0:    c = C_RED;
            3'd1:    c = C_GREEN;
            3'd2:    c = C_BLUE;
            3'd3:    c = C_YELLOW;
            3'd4:    c = C_MAGENTA;
            3'd5:    c = C_CYAN;
            3'd6:    c = C_WHITE;
            3'd7:    c = C_ORANGE;
            default: c = C_BACKGROUND;
        endcase
        return c;
    endfunction

endpackage

@@ src/display_test_pattern_generator.sv @@
// ----------------------------------------------------------------------------
// Display test pattern generator
// Maps a pixel coordinate to its byte-swapped RGB565 color for one of four
// panel test patterns selected by a configuration register.
// ----------------------------------------------------------------------------
// A pixel taken on start passes through the input register and then the
// result register before its color shows on o_pixel_colour with o_strobe high.
// Throughput: one pixel per clock; busy never rises and the receiver cannot
// stall, so every beat taken on start gives exactly one result beat.
// Reset (synchronous, active low) clears both pipeline valid flags, selects
// the edge and ring pattern and sets the solid fill color to zero.
// ----------------------------------------------------------------------------
module display_test_pattern_generator
    import dtpg_pkg::*;
#(
    parameter int PANEL_WIDTH  = 466,
    parameter int PANEL_HEIGHT = 466
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COLOUR_W-1:0]  i_cfg_data,

    // Pixel command channel.
    input  logic                 start,
    output logic                 busy,
    input  logic [COORD_W-1:0]   i_pixel_x,
    input  logic [COORD_W-1:0]   i_pixel_y,

    // Result channel.
    output logic                 o_strobe,
    output logic [COLOUR_W-1:0]  o_pixel_colour
);

    localparam int ZONE_END = ZONE_TOP + ZONE_ROWS * ZONE_COUNT;

    // Configuration registers.
    t_mode               r_mode;
    logic [COLOUR_W-1:0] r_solid;

    // Input register stage.
    logic                r_valid;
    logic [COORD_W-1:0]  r_x, r_y;

    // Result register stage.
    logic                r_strobe;
    logic [COLOUR_W-1:0] r_colour;
    logic [COLOUR_W-1:0] n_colour;

    // Pattern datapath signals.
    logic [COLOUR_W-1:0] ring_colour, ruler_colour;
    logic [COORD_W:0]    ruler_pos;
    logic                in_zone, ge_zone1, ge_zone2, ge_zone3, sep_row;
    logic [1:0]          zone;
    logic [COORD_W-1:0]  zone_base, zone_row;

    // The block never holds the command side off: a new beat can enter in
    // every cycle while the previous one moves to the result register.
    assign busy = 1'b0;

    // The user must issue configuration writes only while no pixel is in flight; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RING;
            r_solid <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PATTERN_MODE: r_mode  <= t_mode'(i_cfg_data[MODE_W-1:0]);
                REG_SOLID_COLOUR: r_solid <= i_cfg_data;
                default:          r_solid <= r_solid;
            endcase
        end
    end

    // Input register: coordinates are payload and carry no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_x <= i_pixel_x;
            r_y <= i_pixel_y;
        end
    end

    // Zone mode splits rows into four bands of equal height. The band number
    // comes from three threshold compares; its first rows are separators.
    assign in_zone  = (r_y >= 9'(ZONE_TOP)) && (r_y < 9'(ZONE_END));
    assign ge_zone1 = r_y >= 9'(ZONE_TOP + ZONE_ROWS);
    assign ge_zone2 = r_y >= 9'(ZONE_TOP + 2 * ZONE_ROWS);
    assign ge_zone3 = r_y >= 9'(ZONE_TOP + 3 * ZONE_ROWS);
    assign zone     = {1'b0, ge_zone1} + {1'b0, ge_zone2} + {1'b0, ge_zone3};
    assign zone_base = 9'(ZONE_TOP) + 9'(zone) * 9'(ZONE_ROWS);
    assign zone_row  = r_y - zone_base;
    assign sep_row   = zone_row < 9'(ZONE_SEP_ROWS);

    // One ruler unit serves both ruler modes; zone mode shifts the sample
    // point right by eight pixels per band.
    assign ruler_pos = (r_mode == MODE_ZONES) ?
                       ({1'b0, r_x} + 10'(zone) * 10'(ZONE_SHIFT)) : {1'b0, r_x};

    dtpg_ring #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_ring (
        .i_x      (r_x),
        .i_y      (r_y),
        .o_colour (ring_colour)
    );

    dtpg_ruler #(
        .PANEL_WIDTH (PANEL_WIDTH)
    ) u_ruler (
        .i_pos    (ruler_pos),
        .o_colour (ruler_colour)
    );

    // Final selection by pattern mode.
    always_comb begin
        case (r_mode)
            MODE_RING:  n_colour = ring_colour;
            MODE_RULER: n_colour = ruler_colour;
            MODE_ZONES: begin
                if (!in_zone) begin
                    n_colour = C_BACKGROUND;
                end else if (sep_row) begin
                    n_colour = C_WHITE;
                end else begin
                    n_colour = ruler_colour;
                end
            end
            MODE_SOLID: n_colour = r_solid;
            default:    n_colour = C_BACKGROUND;
        endcase
    end

    // Result register: each result beat is shown for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_valid) begin
            r_colour <= n_colour;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_pixel_colour = r_colour;

    // Every accepted beat yields a result beat on o_strobe.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe)
        else $error("accepted pixel produced no result beat");

    // No result beat appears without an accepted beat before it.
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |=> ##1 !o_strobe)
        else $error("result beat without an accepted pixel");

    // Solid fill shows the programmed color.
    a_solid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(r_mode) == MODE_SOLID)) |-> (o_pixel_colour == $past(r_solid)))
        else $error("solid fill color mismatch");

    // The bottom edge line wins over everything in the ring pattern.
    a_bottom_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(r_mode) == MODE_RING) &&
         ({3'b000, $past(r_y)} >= 12'(PANEL_HEIGHT - EDGE_LINES)))
        |-> (o_pixel_colour == C_YELLOW))
        else $error("bottom edge line not yellow");

endmodule

@@ src/dtpg_ring.sv @@
// ----------------------------------------------------------------------------
// Edge and ring pattern
// Background, an inner and an outer thin ring, a centre cross and a line along each panel edge.
// ----------------------------------------------------------------------------
module dtpg_ring
    import dtpg_pkg::*;
#(
    parameter int PANEL_WIDTH  = 466,
    parameter int PANEL_HEIGHT = 466
) (
    input  logic [COORD_W-1:0]  i_x,
    input  logic [COORD_W-1:0]  i_y,
    output logic [COLOUR_W-1:0] o_colour
);

    localparam int CX = PANEL_WIDTH / 2;
    localparam int CY = PANEL_HEIGHT / 2;
    localparam logic signed [11:0] ARM_P  = 12'(CROSS_ARM);
    localparam logic signed [11:0] ARM_N  = -12'(CROSS_ARM);
    localparam logic signed [11:0] HALF_P = 12'(CROSS_HALF);
    localparam logic signed [11:0] HALF_N = -12'(CROSS_HALF);

    logic signed [11:0] dx2, dy2, dx, dy;
    logic signed [23:0] sq_x, sq_y, dist_sq;
    logic               on_outer, on_inner, on_cross;

    // Doubled coordinates put the test point at the pixel centre.
    assign dx2 = $signed({2'b00, i_x, 1'b1}) - $signed(12'(2 * CX));
    assign dy2 = $signed({2'b00, i_y, 1'b1}) - $signed(12'(2 * CY));
    assign sq_x = dx2 * dx2;
    assign sq_y = dy2 * dy2;
    assign dist_sq = sq_x + sq_y;

    assign dx = $signed({3'b000, i_x}) - $signed(12'(CX));
    assign dy = $signed({3'b000, i_y}) - $signed(12'(CY));

    assign on_outer = (dist_sq > OUTER_LO) && (dist_sq < OUTER_HI);
    assign on_inner = (dist_sq > INNER_LO) && (dist_sq < INNER_HI);
    assign on_cross = ((dx >= ARM_N) && (dx <= ARM_P) && (dy >= HALF_N) && (dy <= HALF_P)) ||
                      ((dy >= ARM_N) && (dy <= ARM_P) && (dx >= HALF_N) && (dx <= HALF_P));

    // Highest priority last: bottom, top, right and left edges beat the rest.
    always_comb begin
        o_colour = C_BACKGROUND;
        if (on_outer) o_colour = C_WHITE;
        if (on_inner) o_colour = C_CYAN;
        if (on_cross) o_colour = C_WHITE;
        if ({3'b000, i_x} <= 12'(EDGE_LINES - 1)) o_colour = C_RED;
        if ({3'b000, i_x} >= 12'(PANEL_WIDTH - EDGE_LINES)) o_colour = C_GREEN;
        if ({3'b000, i_y} <= 12'(EDGE_LINES - 1)) o_colour = C_BLUE;
        if ({3'b000, i_y} >= 12'(PANEL_HEIGHT - EDGE_LINES)) o_colour = C_YELLOW;
    end

endmodule

@@ src/dtpg_ruler.sv @@
// ----------------------------------------------------------------------------
// Color ruler
// Eight-pixel palette bands inward from the left and the right panel edge.
// ----------------------------------------------------------------------------
module dtpg_ruler
    import dtpg_pkg::*;
#(
    parameter int PANEL_WIDTH = 466
) (
    input  logic [COORD_W:0]    i_pos,
    output logic [COLOUR_W-1:0] o_colour
);

    localparam int RIGHT_LO = PANEL_WIDTH - RULER_SPAN;

    logic [COORD_W+1:0] pos;
    logic [COORD_W+1:0] from_right;

    assign pos        = {1'b0, i_pos};
    assign from_right = 11'(PANEL_WIDTH - 1) - pos;

    // The left ruler wins where the two ranges overlap on a narrow panel.
    always_comb begin
        if (pos < 11'(RULER_SPAN)) begin
            o_colour = palette_colour(pos[5:3]);
        end else if ((pos >= 11'(RIGHT_LO)) && (pos < 11'(PANEL_WIDTH))) begin
            o_colour = palette_colour(from_right[5:3]);
        end else begin
            o_colour = C_BACKGROUND;
        end
    end

endmodule
